### rtl/core/fpl2_pkg.sv
package fpl2_pkg;

	localparam int unsigned VALUE_W = 31;
	localparam int unsigned LOG_W   = 21;
	// signed integer part of the log, covers -32..+31
	localparam int unsigned INT_W   = 6;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_NORM   = 4'b0010,
		ST_SQUARE = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

### rtl/core/fpl2_sqr.sv
module fpl2_sqr #(
	parameter int unsigned ZW = 17
) (
	input  logic            clk,
	input  logic            en,
	input  logic [ZW-1:0]   operand,
	output logic [2*ZW-1:0] product
);

	logic [2*ZW-1:0] product_q;

	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= operand * operand;
		end
	end

	assign product = product_q;

endmodule

### rtl/core/fixed_point_log2_top.sv
// Base-2 logarithm of an unsigned fixed-point operand, FRACT_BITS fraction bits in and out.
// The operand is masked to its low DATA_WIDTH-1 bits; a zero operand skips normalization
// and squaring and returns invalid=1 and log_out=0. Any other request is captured, then
// normalized by a one-bit shifter, one bit per step (|msb position - FRACT_BITS| steps, at
// most the larger of FRACT_BITS and DATA_WIDTH-2-FRACT_BITS), then runs rounds 0 to
// FRACT_BITS on the shared squaring multiplier before the output register is loaded; a
// result still held in the output register stalls the load. A finished result waits in
// the output register, so the next request is taken while it is still pending. The result
// is truncated and log_out keeps the low 21 bits of the two's complement logarithm.
module fixed_point_log2_top #(
	parameter int unsigned FRACT_BITS = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fpl2_pkg::VALUE_W-1:0]       value_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [fpl2_pkg::LOG_W-1:0]  log_out,
	output logic                               invalid
);

	localparam int unsigned XW    = (DATA_WIDTH - 1 > FRACT_BITS + 2) ?
		DATA_WIDTH - 1 : FRACT_BITS + 2;
	localparam int unsigned ZW    = FRACT_BITS + 1;
	localparam int unsigned RW    = $clog2(FRACT_BITS + 1);
	localparam int unsigned ACC_W = FRACT_BITS + fpl2_pkg::INT_W;
	localparam logic signed [fpl2_pkg::INT_W-1:0] INT_ONE =
		{{(fpl2_pkg::INT_W-1){1'b0}}, 1'b1};

	fpl2_pkg::state_t state_q;

	logic [XW-1:0]                       x_q;
	logic signed [fpl2_pkg::INT_W-1:0]   intg_q;
	logic [FRACT_BITS-1:0]               frac_q;
	logic [RW-1:0]                       round_q;
	logic                                zero_q;
	logic                                out_valid_q;
	logic signed [fpl2_pkg::LOG_W-1:0]   log_q;
	logic                                invalid_q;

	logic                                sq_en;
	logic [ZW-1:0]                       sq_operand;
	logic [2*ZW-1:0]                     sq_product;
	logic                                ge2;
	logic [ZW-1:0]                       z_next;
	logic                                last_round;
	logic                                out_free;
	logic signed [ACC_W-1:0]             acc_s;
	logic signed [63:0]                  acc_ext;

	fpl2_sqr #(.ZW(ZW)) u_sqr (
		.clk     (clk),
		.en      (sq_en),
		.operand (sq_operand),
		.product (sq_product)
	);

	// product / 2^F reaching 2 shows up as the top product bit
	assign ge2        = sq_product[2*FRACT_BITS+1];
	assign z_next     = ge2 ? sq_product[2*FRACT_BITS+1:FRACT_BITS+1]
	                        : sq_product[2*FRACT_BITS:FRACT_BITS];
	assign last_round = (round_q == RW'(FRACT_BITS));
	assign sq_en      = (state_q == fpl2_pkg::ST_SQUARE) && !last_round;
	assign sq_operand = (round_q == '0) ? x_q[FRACT_BITS:0] : z_next;
	assign out_free   = !out_valid_q || out_ready;

	assign acc_s   = {intg_q, frac_q};
	assign acc_ext = 64'(acc_s);

	assign in_ready  = (state_q == fpl2_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign log_out   = log_q;
	assign invalid   = invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpl2_pkg::ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == fpl2_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				fpl2_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= (value_in[DATA_WIDTH-2:0] == '0) ?
							fpl2_pkg::ST_FINISH : fpl2_pkg::ST_NORM;
					end
				end
				fpl2_pkg::ST_NORM: begin
					if (x_q[XW-1:FRACT_BITS] == '0) begin
					end else if (x_q[XW-1:FRACT_BITS+1] != '0) begin
					end else begin
						state_q <= fpl2_pkg::ST_SQUARE;
						round_q <= '0;
					end
				end
				fpl2_pkg::ST_SQUARE: begin
					if (last_round) begin
						state_q <= fpl2_pkg::ST_FINISH;
					end else begin
						round_q <= round_q + 1'b1;
					end
				end
				fpl2_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= fpl2_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fpl2_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fpl2_pkg::ST_IDLE: begin
				if (in_valid) begin
					x_q    <= XW'(value_in[DATA_WIDTH-2:0]);
					zero_q <= (value_in[DATA_WIDTH-2:0] == '0);
					intg_q <= '0;
					frac_q <= '0;
				end
			end
			fpl2_pkg::ST_NORM: begin
				if (x_q[XW-1:FRACT_BITS] == '0) begin
					x_q    <= x_q << 1;
					intg_q <= intg_q - INT_ONE;
				end else if (x_q[XW-1:FRACT_BITS+1] != '0) begin
					x_q    <= x_q >> 1;
					intg_q <= intg_q + INT_ONE;
				end
			end
			fpl2_pkg::ST_SQUARE: begin
				// round 0 only launches the first square
				if (round_q != '0) begin
					frac_q <= (frac_q << 1) | FRACT_BITS'(ge2);
				end
			end
			fpl2_pkg::ST_FINISH: begin
				if (out_free) begin
					log_q     <= zero_q ? '0 : acc_ext[fpl2_pkg::LOG_W-1:0];
					invalid_q <= zero_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpl2_pkg::ST_SQUARE && round_q == '0) |->
			(x_q[XW-1:FRACT_BITS] == 1))
		else $error("squaring started on an operand outside [1,2)");

	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpl2_pkg::ST_NORM) |-> (x_q != '0))
		else $error("normalizer running on a zero operand");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpl2_pkg::ST_SQUARE) |-> (round_q <= RW'(FRACT_BITS)))
		else $error("squaring round count overran");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && invalid) |-> (log_out == '0))
		else $error("invalid result carries a nonzero log");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpl2_pkg::ST_FINISH && out_free) |=> out_valid)
		else $error("finished request did not reach the output register");

endmodule

### verif/testbench.sv
module testbench;

	localparam int unsigned FRACT_BITS = 16;
	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned RANDOM_REQS = 1900;

	typedef struct packed {
		logic signed [fpl2_pkg::LOG_W-1:0] log_val;
		logic                              invalid;
	} log2_result_t;

	typedef struct packed {
		logic [fpl2_pkg::VALUE_W-1:0] value;
		logic                         drain_first;
	} operand_req_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [fpl2_pkg::VALUE_W-1:0]       value_in = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [fpl2_pkg::LOG_W-1:0]  log_out;
	logic                               invalid;

	operand_req_t operand_queue[$];
	log2_result_t log_queue[$];
	log2_result_t head_log;

	int issued_cnt = 0;
	int logs_checked = 0;
	int failures = 0;
	int gap_left = 0;
	int burst_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int rx_mode = 0;
	int rx_mode_left = 0;

	fixed_point_log2_top #(
		.FRACT_BITS(FRACT_BITS),
		.DATA_WIDTH(DATA_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value_in(value_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.log_out(log_out),
		.invalid(invalid)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// normalize into [1,2), then one fraction bit per squaring round, truncated
	function automatic log2_result_t log2_of(logic [fpl2_pkg::VALUE_W-1:0] operand);
		logic [63:0] x;
		logic [63:0] z;
		logic [63:0] acc;
		logic [63:0] frac_step;
		logic [63:0] fx_one;
		logic [63:0] fx_two;
		log2_result_t r;
		fx_one = 64'd1 << FRACT_BITS;
		fx_two = 64'd2 << FRACT_BITS;
		x = {33'd0, operand} & ((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
		acc = '0;
		if (x == 0) begin
			r.log_val = '0;
			r.invalid = 1'b1;
			return r;
		end
		while (x < fx_one) begin
			x = x << 1;
			acc = acc - fx_one;
		end
		while (x >= fx_two) begin
			x = x >> 1;
			acc = acc + fx_one;
		end
		z = x;
		frac_step = 64'd1 << (FRACT_BITS - 1);
		for (int i = 0; i < FRACT_BITS; i++) begin
			z = (z * z) >> FRACT_BITS;
			if (z >= fx_two) begin
				z = z >> 1;
				acc = acc + frac_step;
			end
			frac_step = frac_step >> 1;
		end
		r.log_val = acc[fpl2_pkg::LOG_W-1:0];
		r.invalid = 1'b0;
		return r;
	endfunction

	task automatic add_request(logic [fpl2_pkg::VALUE_W-1:0] value, logic drain_first);
		operand_req_t req;
		req.value = value;
		req.drain_first = drain_first;
		operand_queue.push_back(req);
	endtask

	// sender: bursts of requests separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value_in <= '0;
			gap_left <= 0;
			burst_left <= 0;
			issued_cnt <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				log_queue.push_back(log2_of(value_in));
				issued_cnt <= issued_cnt + 1;
			end
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (operand_queue.size() == 0 || (operand_queue[0].drain_first &&
					(in_valid || issued_cnt != logs_checked))) begin
				// a drain request waits until every outstanding log has come back
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				value_in <= operand_queue[0].value;
				operand_queue.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver: changing stall patterns plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
			rx_mode <= 0;
			rx_mode_left <= 0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && logs_checked >= 500) begin
			out_ready <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= 400;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_mode_left <= $urandom_range(16, 128);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 7) != 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			logs_checked <= logs_checked + 1;
			if (log_queue.size() == 0) begin
				$error("unexpected result: log_out %0d invalid %0d", log_out, invalid);
				failures++;
			end else begin
				head_log = log_queue.pop_front();
				if (log_out !== head_log.log_val) begin
					$error("log_out mismatch: expected %0d, actual %0d",
						head_log.log_val, log_out);
					failures++;
				end
				if (invalid !== head_log.invalid) begin
					$error("invalid mismatch: expected %0d, actual %0d",
						head_log.invalid, invalid);
					failures++;
				end
			end
		end
	end

	initial begin
		int msb;
		logic [31:0] rnd;
		logic [fpl2_pkg::VALUE_W-1:0] v;
		// corner operands: zero, smallest, one, largest, powers of two, near-one values
		add_request('0, 1'b0);
		add_request(31'd1, 1'b0);
		add_request(31'h0001_0000, 1'b0);
		add_request(31'h7FFF_FFFF, 1'b0);
		add_request(31'h4000_0000, 1'b0);
		add_request(31'h0000_FFFF, 1'b0);
		add_request(31'h0001_0001, 1'b0);
		add_request(31'h0001_FFFF, 1'b0);
		add_request(31'h0002_0000, 1'b0);
		add_request(31'h0001_8000, 1'b0);
		add_request(31'd92682, 1'b0);
		add_request(31'h5555_5555, 1'b0);
		add_request(31'h2AAA_AAAA, 1'b0);
		add_request(31'h0000_8000, 1'b0);
		add_request(31'd3, 1'b0);
		add_request(31'd2, 1'b0);
		add_request(31'h4000_0001, 1'b0);
		add_request(31'h3FFF_FFFF, 1'b0);
		add_request('0, 1'b0);
		add_request(31'h0000_7FFF, 1'b0);
		add_request(31'h0001_0000, 1'b0);
		for (int n = 0; n < RANDOM_REQS; n++) begin
			case ($urandom_range(0, 15))
				0: v = '0;
				1, 2, 3: begin
					rnd = $urandom();
					v = rnd[fpl2_pkg::VALUE_W-1:0];
				end
				default: begin
					// pick the leading one position so every exponent gets hit
					msb = $urandom_range(0, fpl2_pkg::VALUE_W - 1);
					rnd = $urandom();
					v = rnd[fpl2_pkg::VALUE_W-1:0];
					v = v & ((31'd1 << msb) - 31'd1);
					v = v | (31'd1 << msb);
				end
			endcase
			add_request(v, (n % 400) == 0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (operand_queue.size() != 0 || in_valid || issued_cnt != logs_checked)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (log_queue.size() != 0) begin
			$error("%0d expected results never arrived", log_queue.size());
			failures++;
		end
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule

### files.f
rtl/core/fpl2_pkg.sv
rtl/core/fpl2_sqr.sv
rtl/core/fixed_point_log2_top.sv
verif/testbench.sv
